[rtl/bgam_pkg.sv]
// ----------------------------------------------------------------------------
// bgam_pkg
// Types and constants for the battery gauge: window average and level map.
// ----------------------------------------------------------------------------
package bgam_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int THR_W        = 16;
    localparam int LEVEL_W      = 7;
    // power of two: the average is a right shift of the sum
    localparam int WINDOW_DEPTH = 64;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = SAMPLE_W + WIN_AW;
    localparam int PDIFF_W      = 6;
    localparam int NUM_W        = SAMPLE_W + PDIFF_W;
    localparam int DEN_W        = THR_W;
    localparam int CNT_W        = $clog2(NUM_W);

    localparam logic [LEVEL_W-1:0] PCT_ZERO = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] PCT_LOW  = LEVEL_W'(20);
    localparam logic [LEVEL_W-1:0] PCT_HIGH = LEVEL_W'(80);
    localparam logic [LEVEL_W-1:0] PCT_FULL = LEVEL_W'(100);

    localparam logic [THR_W-1:0] THR0_RESET   = THR_W'(600);
    localparam logic [THR_W-1:0] THR20_RESET  = THR_W'(700);
    localparam logic [THR_W-1:0] THR80_RESET  = THR_W'(800);
    localparam logic [THR_W-1:0] THR100_RESET = THR_W'(900);

    typedef enum logic [1:0] {
        REG_LEVEL0,
        REG_LEVEL20,
        REG_LEVEL80,
        REG_LEVEL100
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MAP,
        ST_DIV,
        ST_DONE
    } gauge_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                preset;
    } sample_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [LEVEL_W-1:0]  level_percent;
    } result_word_t;

    typedef struct packed {
        logic                update;
        logic                preset;
        logic [SAMPLE_W-1:0] sample;
    } win_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic [NUM_W-1:0] quotient;
    } div_stat_t;

endpackage

[rtl/bgam_window.sv]
// ----------------------------------------------------------------------------
// bgam_window
// Sample ring with running sum; preset refills the window through valid bits.
// ----------------------------------------------------------------------------
module bgam_window
    import bgam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  win_ctrl_t        ctrl,
    output logic [SUM_W-1:0] sum
);

    logic [SAMPLE_W-1:0]     mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]     rdata_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [SAMPLE_W-1:0]     fill_reg, fill_next;
    logic [WIN_AW-1:0]       pos_reg, pos_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [WIN_AW-1:0]       wr_addr;
    logic [SAMPLE_W-1:0]     old_value;

    // invalid entries hold the last preset value
    always_comb
    begin
        wr_addr    = ctrl.preset ? '0 : pos_reg;
        old_value  = valid_reg[pos_reg] ? rdata_reg : fill_reg;
        valid_next = valid_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        if (ctrl.update)
        begin
            if (ctrl.preset)
            begin
                valid_next = '0;
                fill_next  = ctrl.sample;
                sum_next   = SUM_W'(ctrl.sample) << WIN_AW;
            end
            else
            begin
                sum_next = sum_reg - SUM_W'(old_value) + SUM_W'(ctrl.sample);
            end
            valid_next[wr_addr] = 1'b1;
            pos_next = (wr_addr == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : wr_addr + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            mem[wr_addr] <= ctrl.sample;
        end
        rdata_reg <= mem[pos_reg];
    end

    assign sum = sum_reg;

endmodule

[rtl/bgam_div.sv]
// ----------------------------------------------------------------------------
// bgam_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgam_div
    import bgam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_stat_t        stat
);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : shifted;
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.quotient = quo_reg;

endmodule

[rtl/battery_gauge_average_map_unit.sv]
// ----------------------------------------------------------------------------
// battery_gauge_average_map_unit
// Moving average of battery samples, mapped to a 0-100 percent level.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               word
//  sample    in         sample_valid/stall      sample, preset
//  result    out        result_valid/stall      average, level_percent
//  config    in         cfg_we, cfg_index       cfg_data (16 bits)
//
//  An item inside a segment has its result valid after the window update, the
//  segment map and the shared restoring divider; outside all segments it skips
//  the divider. The next word is taken once the result sits in the output
//  register, so a new word waits until the last result is loaded.
//  Reset empties the window at once (valid bits); no clearing pass.
//  A stalled result holds in the output register and blocks only the last step.
// ----------------------------------------------------------------------------
module battery_gauge_average_map_unit
    import bgam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  sample_word_t        sample_word,
    output logic                result_valid,
    input  logic                result_stall,
    output result_word_t        result_word,
    input  logic                cfg_we,
    input  cfg_index_t          cfg_index,
    input  logic [THR_W-1:0]    cfg_data
);

    gauge_state_t        state_reg, state_next;
    logic [THR_W-1:0]    thr_reg [4];
    sample_word_t        item_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [LEVEL_W-1:0]  base_reg;
    logic                use_div_reg;
    logic                out_valid_reg, out_valid_next;
    result_word_t        out_word_reg;

    win_ctrl_t           win_ctrl;
    logic [SUM_W-1:0]    sum;
    div_stat_t           div_stat;
    logic                div_start;

    logic                accept;
    logic                load_out;
    logic [SAMPLE_W-1:0] avg;
    logic [THR_W-1:0]    seg_lo, seg_hi;
    logic [LEVEL_W-1:0]  base;
    logic [PDIFF_W-1:0]  pdiff;
    logic                in_seg;
    logic                need_div;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    span;

    assign accept = sample_valid && !sample_stall;
    assign avg    = sum[SUM_W-1:WIN_AW];

    // segment select
    always_comb
    begin
        seg_lo = '0;
        seg_hi = '0;
        base   = PCT_ZERO;
        pdiff  = '0;
        in_seg = 1'b0;
        priority if (avg >= thr_reg[REG_LEVEL100])
        begin
            base = PCT_FULL;
        end
        else if (avg >= thr_reg[REG_LEVEL80])
        begin
            in_seg = 1'b1;
            seg_lo = thr_reg[REG_LEVEL80];
            seg_hi = thr_reg[REG_LEVEL100];
            base   = PCT_HIGH;
            pdiff  = PDIFF_W'(PCT_FULL - PCT_HIGH);
        end
        else if (avg >= thr_reg[REG_LEVEL20])
        begin
            in_seg = 1'b1;
            seg_lo = thr_reg[REG_LEVEL20];
            seg_hi = thr_reg[REG_LEVEL80];
            base   = PCT_LOW;
            pdiff  = PDIFF_W'(PCT_HIGH - PCT_LOW);
        end
        else if (avg >= thr_reg[REG_LEVEL0])
        begin
            in_seg = 1'b1;
            seg_lo = thr_reg[REG_LEVEL0];
            seg_hi = thr_reg[REG_LEVEL20];
            base   = PCT_ZERO;
            pdiff  = PDIFF_W'(PCT_LOW - PCT_ZERO);
        end
        else
        begin
            base = PCT_ZERO;
        end
        need_div = in_seg && (seg_hi > seg_lo);
        span     = seg_hi - seg_lo;
        num      = NUM_W'(avg - seg_lo) * NUM_W'(pdiff);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                state_next = need_div ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (!div_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        sample_stall    = (state_reg != ST_IDLE);
        win_ctrl.update = (state_reg == ST_UPDATE);
        win_ctrl.preset = item_reg.preset;
        win_ctrl.sample = item_reg.sample;
        div_start       = (state_reg == ST_MAP) && need_div;
        load_out        = (state_reg == ST_DONE) && (!out_valid_reg || !result_stall);
        out_valid_next  = load_out || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            out_valid_reg        <= 1'b0;
            thr_reg[REG_LEVEL0]   <= THR0_RESET;
            thr_reg[REG_LEVEL20]  <= THR20_RESET;
            thr_reg[REG_LEVEL80]  <= THR80_RESET;
            thr_reg[REG_LEVEL100] <= THR100_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LEVEL0:   thr_reg[REG_LEVEL0]   <= cfg_data;
                    REG_LEVEL20:  thr_reg[REG_LEVEL20]  <= cfg_data;
                    REG_LEVEL80:  thr_reg[REG_LEVEL80]  <= cfg_data;
                    REG_LEVEL100: thr_reg[REG_LEVEL100] <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sample_word;
        end
        if (state_reg == ST_MAP)
        begin
            avg_reg     <= avg;
            base_reg    <= base;
            use_div_reg <= need_div;
        end
        if (load_out)
        begin
            out_word_reg.average       <= avg_reg;
            out_word_reg.level_percent <= base_reg +
                (use_div_reg ? div_stat.quotient[LEVEL_W-1:0] : PCT_ZERO);
        end
    end

    bgam_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (win_ctrl),
        .sum   (sum)
    );

    bgam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (span),
        .stat  (div_stat)
    );

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

[rtl/bgam_checker.sv]
// ----------------------------------------------------------------------------
// bgam_checker
// Port-level checks for the battery gauge, bound to the top level.
// ----------------------------------------------------------------------------
module bgam_checker
    import bgam_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         sample_valid,
    input logic         sample_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_word_t result_word
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_word))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample taken while previous word in work");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_word.level_percent <= PCT_FULL))
        else $error("level above full scale");

endmodule

bind battery_gauge_average_map_unit bgam_checker u_bgam_checker (.*);
